// ===== src/shash_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 stream hash package
// Round constants, initial hash values, round functions and FSM type.
// ----------------------------------------------------------------------------
package shash_pkg;

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StPad  = 6'b000010,
    StLoad = 6'b000100,
    StComp = 6'b001000,
    StAdd  = 6'b010000,
    StOut  = 6'b100000
  } state_e;

  localparam logic FuncAbsorb = 1'b0;
  localparam logic FuncFinish = 1'b1;

  localparam logic [7:0] PadByte = 8'h80;

  typedef logic [31:0] word_t;

  localparam word_t InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t v, input int unsigned n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

  function automatic word_t bsig0(input word_t v);
    bsig0 = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
  endfunction

  function automatic word_t bsig1(input word_t v);
    bsig1 = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
  endfunction

  function automatic word_t ssig0(input word_t v);
    ssig0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
  endfunction

  function automatic word_t ssig1(input word_t v);
    ssig1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
  endfunction

endpackage

// ===== src/shash_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module shash_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/sha256_stream_hash.sv =====
// ----------------------------------------------------------------------------
// SHA-256 stream hash
// Absorb: a byte is taken whenever idle; the 64th byte of a block starts a
// compression (load, 64 rounds at one per cycle, chain update).
// Finish: (16 - word position) pad writes, then one or two compressions (with
// 16 more pad writes before the second), then 8 digest transactions.
// Async active-low reset: initial hash values, zero length, idle.
// ----------------------------------------------------------------------------
module sha256_stream_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] func
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [31:0] digest_word, [34:32] word_index
  output logic        m_axis_tlast_o    // last_word
);
  import shash_pkg::*;

  state_e      state_q, state_d;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] bits_q, bits_d;
  logic [23:0] acc_q, acc_d;
  word_t       h_q [8];
  word_t       h_d [8];
  word_t       r_q [8];
  word_t       r_d [8];
  word_t       w_q [16];
  word_t       w_d [16];
  logic [5:0]  rnd_q, rnd_d;
  logic [3:0]  pidx_q, pidx_d;
  logic [3:0]  cur_q, cur_d;
  word_t       pw_q, pw_d;
  logic        final_q, final_d;
  logic        two_q, two_d;
  logic        pass2_q, pass2_d;
  logic [2:0]  oidx_q, oidx_d;

  logic        ram_we;
  logic [3:0]  ram_waddr, ram_raddr;
  word_t       ram_wdata, ram_rdata;
  word_t       w_t, t1, t2;
  logic        in_acc;

  shash_ram #(.Width(32), .Depth(16)) u_blk (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready_o = (state_q == StIdle);
  assign in_acc          = s_axis_tvalid_i & s_axis_tready_o;
  assign m_axis_tvalid_o = (state_q == StOut);
  assign m_axis_tdata_o  = {5'd0, oidx_q, h_q[oidx_q]};
  assign m_axis_tlast_o  = (oidx_q == 3'd7);

  always_comb begin
    if (rnd_q < 6'd16) begin
      w_t = ram_rdata;
    end else begin
      w_t = ssig1(w_q[14]) + w_q[9] + ssig0(w_q[1]) + w_q[0];
    end
    t1 = r_q[7] + bsig1(r_q[4]) + ((r_q[4] & r_q[5]) ^ (~r_q[4] & r_q[6]))
       + RoundK[rnd_q] + w_t;
    t2 = bsig0(r_q[0]) + ((r_q[0] & r_q[1]) ^ (r_q[0] & r_q[2]) ^ (r_q[1] & r_q[2]));
  end

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    bits_d    = bits_q;
    acc_d     = acc_q;
    h_d       = h_q;
    r_d       = r_q;
    w_d       = w_q;
    rnd_d     = rnd_q;
    pidx_d    = pidx_q;
    cur_d     = cur_q;
    pw_d      = pw_q;
    final_d   = final_q;
    two_d     = two_q;
    pass2_d   = pass2_q;
    oidx_d    = oidx_q;
    ram_we    = 1'b0;
    ram_waddr = pidx_q;
    ram_wdata = '0;
    ram_raddr = '0;

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (s_axis_tuser_i == FuncAbsorb) begin
            acc_d  = {acc_q[15:0], s_axis_tdata_i};
            fill_d = fill_q + 6'd1;
            bits_d = bits_q + 64'd8;
            if (fill_q[1:0] == 2'd3) begin
              ram_we    = 1'b1;
              ram_waddr = fill_q[5:2];
              ram_wdata = {acc_q, s_axis_tdata_i};
            end
            if (fill_q == 6'd63) begin
              final_d = 1'b0;
              state_d = StLoad;
            end
          end else begin
            unique case (fill_q[1:0])
              2'd0:    pw_d = {PadByte, 24'd0};
              2'd1:    pw_d = {acc_q[7:0], PadByte, 16'd0};
              2'd2:    pw_d = {acc_q[15:0], PadByte, 8'd0};
              default: pw_d = {acc_q, PadByte};
            endcase
            cur_d   = fill_q[5:2];
            pidx_d  = fill_q[5:2];
            two_d   = (fill_q[5:2] >= 4'd14);
            pass2_d = 1'b0;
            final_d = 1'b1;
            state_d = StPad;
          end
        end
      end
      StPad: begin
        ram_we    = 1'b1;
        ram_waddr = pidx_q;
        if (!pass2_q && pidx_q == cur_q) begin
          ram_wdata = pw_q;
        end else if ((pass2_q || !two_q) && pidx_q == 4'd14) begin
          ram_wdata = bits_q[63:32];
        end else if ((pass2_q || !two_q) && pidx_q == 4'd15) begin
          ram_wdata = bits_q[31:0];
        end else begin
          ram_wdata = '0;
        end
        pidx_d = pidx_q + 4'd1;
        if (pidx_q == 4'd15) begin
          state_d = StLoad;
        end
      end
      StLoad: begin
        ram_raddr = 4'd0;
        r_d       = h_q;
        rnd_d     = 6'd0;
        state_d   = StComp;
      end
      StComp: begin
        ram_raddr = rnd_q[3:0] + 4'd1;
        for (int i = 0; i < 15; i++) begin
          w_d[i] = w_q[i+1];
        end
        w_d[15] = w_t;
        r_d[7] = r_q[6];
        r_d[6] = r_q[5];
        r_d[5] = r_q[4];
        r_d[4] = r_q[3] + t1;
        r_d[3] = r_q[2];
        r_d[2] = r_q[1];
        r_d[1] = r_q[0];
        r_d[0] = t1 + t2;
        rnd_d  = rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          state_d = StAdd;
        end
      end
      StAdd: begin
        for (int i = 0; i < 8; i++) begin
          h_d[i] = h_q[i] + r_q[i];
        end
        if (!final_q) begin
          state_d = StIdle;
        end else if (two_q && !pass2_q) begin
          pass2_d = 1'b1;
          pidx_d  = 4'd0;
          state_d = StPad;
        end else begin
          oidx_d  = 3'd0;
          state_d = StOut;
        end
      end
      StOut: begin
        if (m_axis_tready_i) begin
          oidx_d = oidx_q + 3'd1;
          if (oidx_q == 3'd7) begin
            h_d     = InitH;
            fill_d  = 6'd0;
            bits_d  = 64'd0;
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fill_q  <= 6'd0;
      bits_q  <= 64'd0;
      h_q     <= InitH;
      rnd_q   <= 6'd0;
      pidx_q  <= 4'd0;
      final_q <= 1'b0;
      two_q   <= 1'b0;
      pass2_q <= 1'b0;
      oidx_q  <= 3'd0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      bits_q  <= bits_d;
      h_q     <= h_d;
      rnd_q   <= rnd_d;
      pidx_q  <= pidx_d;
      final_q <= final_d;
      two_q   <= two_d;
      pass2_q <= pass2_d;
      oidx_q  <= oidx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    r_q   <= r_d;
    w_q   <= w_d;
    cur_q <= cur_d;
    pw_q  <= pw_d;
  end

endmodule

// ===== tb/sha256_stream_hash_test.sv =====
// ----------------------------------------------------------------------------
// SHA-256 stream hash testbench
// Streams message bytes and finish commands into the engine, predicts each
// digest with a local SHA-256 model and checks every output transaction.
// ----------------------------------------------------------------------------
module sha256_stream_hash_test;
  import shash_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       func;
    logic [7:0] data;
  } byte_cmd_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;
  logic        s_axis_tuser_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  sha256_stream_hash dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  byte_cmd_t    pending_q[$];
  digest_beat_t digest_q[$];
  int           errors = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  bit           in_fire = 1'b0;
  int           msgs_done = 0;
  int           cycles = 0;

  // model state
  word_t       h_st [8];
  logic [7:0]  blk [64];
  logic [5:0]  fill;
  logic [63:0] nbits;

  function automatic word_t rr(word_t v, int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  task automatic compress_blk();
    word_t w [64];
    word_t r [8];
    word_t t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + (rr(w[i-15], 7) ^ rr(w[i-15], 18) ^ (w[i-15] >> 3))
           + w[i-7] + (rr(w[i-2], 17) ^ rr(w[i-2], 19) ^ (w[i-2] >> 10));
    r = h_st;
    for (int i = 0; i < 64; i++) begin
      t1 = r[7] + (rr(r[4], 6) ^ rr(r[4], 11) ^ rr(r[4], 25))
         + ((r[4] & r[5]) ^ (~r[4] & r[6])) + RoundK[i] + w[i];
      t2 = (rr(r[0], 2) ^ rr(r[0], 13) ^ rr(r[0], 22))
         + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
      r[7] = r[6]; r[6] = r[5]; r[5] = r[4]; r[4] = r[3] + t1;
      r[3] = r[2]; r[2] = r[1]; r[1] = r[0]; r[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) h_st[i] += r[i];
  endtask

  task automatic hash_step(byte_cmd_t c);
    int pos;
    if (c.func == FuncAbsorb) begin
      blk[fill] = c.data;
      fill++;
      nbits += 64'd8;
      if (fill == 0) compress_blk();
    end else begin
      pos = fill;
      blk[pos] = PadByte;
      pos++;
      if (pos > 56) begin
        while (pos < 64) blk[pos++] = 8'h00;
        compress_blk();
        pos = 0;
      end
      while (pos < 56) blk[pos++] = 8'h00;
      for (int i = 0; i < 8; i++) blk[56+i] = nbits[63-8*i -: 8];
      compress_blk();
      for (int i = 0; i < 8; i++) digest_q.push_back('{h_st[i], i[2:0], i == 7});
      h_st = InitH;
      fill = '0;
      nbits = '0;
    end
  endtask

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid_i || in_fire) begin
        if (in_fire) pending_q.pop_front();
        if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tuser_i  <= pending_q[0].func;
          s_axis_tdata_i  <= pending_q[0].data;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin
    digest_beat_t e;
    cycles  <= cycles + 1;
    in_fire <= rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o)
      hash_step('{s_axis_tuser_i, s_axis_tdata_i});
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (digest_q.size() == 0) begin
        $error("unexpected digest transaction %h", m_axis_tdata_o);
        errors++;
      end else begin
        e = digest_q.pop_front();
        if (m_axis_tdata_o[31:0] !== e.word) begin
          $error("digest_word exp %h got %h", e.word, m_axis_tdata_o[31:0]);
          errors++;
        end
        if (m_axis_tdata_o[34:32] !== e.idx) begin
          $error("word_index exp %0d got %0d", e.idx, m_axis_tdata_o[34:32]);
          errors++;
        end
        if (m_axis_tlast_o !== e.last) begin
          $error("last_word exp %0d got %0d", e.last, m_axis_tlast_o);
          errors++;
        end
        if (e.last) msgs_done++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > 400000) begin
      $display("timeout");
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic push_msg(int len, bit fixed_val, logic [7:0] v);
    for (int i = 0; i < len; i++)
      pending_q.push_back('{FuncAbsorb, fixed_val ? v : 8'($urandom_range(255))});
    pending_q.push_back('{FuncFinish, 8'($urandom_range(255))});
  endtask

  task automatic drain();
    while (!(pending_q.size() == 0 && !s_axis_tvalid_i && digest_q.size() == 0))
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  int lens [4][2] = '{'{55, 3}, '{56, 9}, '{63, 1}, '{64, 0}};

  initial begin
    h_st  = InitH;
    fill  = '0;
    nbits = '0;
    foreach (blk[i]) blk[i] = 8'h00;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // directed: empty message, 0x00/0xff bytes
    pending_q.push_back('{FuncFinish, 8'hff});
    push_msg(2, 1, 8'h00);
    push_msg(2, 1, 8'hff);
    drain();
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      // padding boundary lengths spread over the phases
      push_msg(lens[p][0], 0, 8'h00);
      push_msg(lens[p][1], 0, 8'h00);
      // back-to-back finishes
      pending_q.push_back('{FuncFinish, 8'h00});
      drain();
    end

    $display("Checked %0d digests over messages of 0 to 64 bytes,", msgs_done);
    $display("including pad boundaries and four idle/stall phases.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
